// ===== rtl/cfld_pkg.sv =====
`timescale 1ns / 1ps
// cfld_pkg: shared types and codes for the clock face led matrix driver
// no dependencies; imported by every rtl file of the block

package cfld_pkg;

  localparam int unsigned CFG_AW = 6;
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned GLYPH_PAIRS = 5;

  typedef struct packed {
    logic        action;
    logic [31:0] timestamp_seconds;
    logic        time_synced;
    logic [10:0] elapsed_ms;
    logic [7:0]  brightness_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] write_kind;
    logic       device_number;
    logic [2:0] row_number;
    logic [2:0] column_number;
    logic [7:0] write_value;
    logic       last_write;
  } out_item_t;

  typedef logic [GLYPH_PAIRS-1:0][47:0] glyph_bank_t;

  localparam logic [1:0] KIND_ROW       = 2'd0;
  localparam logic [1:0] KIND_LED       = 2'd1;
  localparam logic [1:0] KIND_INTENSITY = 2'd2;

  // divider phases
  localparam logic [1:0] PH_DAY  = 2'd0;
  localparam logic [1:0] PH_HOUR = 2'd1;
  localparam logic [1:0] PH_MIN  = 2'd2;

  // output word sources
  localparam logic [1:0] EMIT_INTENSITY = 2'd0;
  localparam logic [1:0] EMIT_ROW       = 2'd1;
  localparam logic [1:0] EMIT_LED       = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       load_sum;
    logic       div_step;
    logic [1:0] div_phase;
    logic       div_rem;
    logic       latch_hour;
    logic       decide;
    logic       set_digit;
    logic [1:0] digit_idx;
    logic       emit;
    logic [1:0] emit_sel;
    logic [2:0] sub_idx;
    logic       emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       action;
    logic       ts_changed;
    logic       colon_write;
    logic [3:0] digit_chg;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/cfld_cfg_regs.sv =====
`timescale 1ns / 1ps
// cfld_cfg_regs: apb-style register file for time zone offset and glyph pairs
// depends on cfld_pkg

module cfld_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cfld_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cfld_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cfld_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [17:0]                  tz_offset,
  output cfld_pkg::glyph_bank_t        glyphs
);
  import cfld_pkg::*;

  localparam logic [2:0] REG_TZ_OFFSET    = 3'd0;
  localparam logic [2:0] REG_GLYPH_PAIR_0 = 3'd1;
  localparam logic [2:0] REG_GLYPH_PAIR_1 = 3'd2;
  localparam logic [2:0] REG_GLYPH_PAIR_2 = 3'd3;
  localparam logic [2:0] REG_GLYPH_PAIR_3 = 3'd4;
  localparam logic [2:0] REG_GLYPH_PAIR_4 = 3'd5;

  logic [17:0]  tz_r;
  glyph_bank_t  glyph_r;
  logic         wr_en;
  logic [2:0]   reg_idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;
  assign tz_offset  = tz_r;
  assign glyphs     = glyph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r    <= '0;
      glyph_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TZ_OFFSET:    tz_r       <= cfg_pwdata[17:0];
        REG_GLYPH_PAIR_0: glyph_r[0] <= cfg_pwdata[47:0];
        REG_GLYPH_PAIR_1: glyph_r[1] <= cfg_pwdata[47:0];
        REG_GLYPH_PAIR_2: glyph_r[2] <= cfg_pwdata[47:0];
        REG_GLYPH_PAIR_3: glyph_r[3] <= cfg_pwdata[47:0];
        REG_GLYPH_PAIR_4: glyph_r[4] <= cfg_pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TZ_OFFSET:    cfg_prdata = {46'd0, tz_r};
      REG_GLYPH_PAIR_0: cfg_prdata = {16'd0, glyph_r[0]};
      REG_GLYPH_PAIR_1: cfg_prdata = {16'd0, glyph_r[1]};
      REG_GLYPH_PAIR_2: cfg_prdata = {16'd0, glyph_r[2]};
      REG_GLYPH_PAIR_3: cfg_prdata = {16'd0, glyph_r[3]};
      REG_GLYPH_PAIR_4: cfg_prdata = {16'd0, glyph_r[4]};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/cfld_datapath.sv =====
`timescale 1ns / 1ps
// cfld_datapath: request capture, colon countdown, reciprocal-multiply time divider,
// digit store, glyph row assembly and output register; depends on cfld_pkg

module cfld_datapath #(
  parameter int unsigned COLON_PERIOD_MS = 2000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfld_pkg::in_item_t    in_data,
  input  logic [17:0]           tz_offset,
  input  cfld_pkg::glyph_bank_t glyphs,
  input  cfld_pkg::dp_cmd_t     cmd,
  output cfld_pkg::dp_status_t  status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output cfld_pkg::out_item_t   out_data
);
  import cfld_pkg::*;

  localparam int unsigned LW = $clog2(COLON_PERIOD_MS + 1);
  localparam int unsigned EW = 11;
  localparam int unsigned CW = (LW > EW) ? LW : EW;
  localparam int unsigned PW = CW + 17;
  localparam logic [LW-1:0] PERIOD     = LW'(COLON_PERIOD_MS);
  localparam logic [CW-1:0] SYNC_LIMIT = CW'(1000);
  // ceil(2^23 / 250), exact quotient for counts below 4096
  localparam logic [16:0] QUARTER_RECIP = 17'd33555;
  localparam int unsigned QUARTER_SHIFT = 23;
  localparam logic [2:0]  STAGE_DARK = 3'd4;
  localparam logic [2:0]  STAGE_LIT  = 3'd5;
  localparam logic [16:0] DAY_SECONDS    = 17'd86400;
  localparam logic [16:0] HOUR_SECONDS   = 17'd3600;
  localparam logic [33:0] DAY_BIAS       = 34'(DAY_SECONDS) << 1;
  // day: (x >> 7) / 675, hour: (t >> 4) / 225, minute: (t >> 2) / 15
  localparam logic [26:0] DAY_RECIP  = 27'd101806633;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  function automatic logic [3:0] colon_pattern(input logic [2:0] stage);
    logic [3:0] p;
    unique case (stage)
      3'd0:    p = 4'b1001;
      3'd1:    p = 4'b0011;
      3'd2:    p = 4'b0110;
      3'd3:    p = 4'b1100;
      3'd5:    p = 4'b1111;
      default: p = 4'b0000;
    endcase
    return p;
  endfunction

  // quotient by ten for values below 64
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return 4'(p[9:7]);
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t;
    t = 6'(tens_of(v)) * 6'd10;
    return 4'(v - t);
  endfunction

  function automatic logic [2:0] glyph_row(input glyph_bank_t bank, input logic [3:0] d,
                                           input logic [2:0] r);
    logic [3:0]  dd;
    logic [47:0] pair;
    logic [23:0] half;
    logic [4:0]  pos;
    dd   = (d >= 4'd10) ? d - 4'd10 : d;
    pair = bank[dd[3:1]];
    half = dd[0] ? pair[47:24] : pair[23:0];
    pos  = 5'({r, 1'b0}) + 5'(r);
    return half[pos +: 3];
  endfunction

  // persistent state
  logic [31:0]      last_ts_r;
  logic [2:0]       stage_r;
  logic [LW-1:0]    left_r;
  logic [3:0][3:0]  shown_r;
  logic             out_valid_r;
  // per-request payload
  out_item_t        out_data_r;
  logic [31:0]      ts_r;
  logic             action_r;
  logic             ts_changed_r;
  logic             colon_write_r;
  logic [3:0]       bright_r;
  logic [33:0]      rem_r;
  logic [16:0]      quo_r;
  logic [4:0]       hour_r;
  logic [3:0][3:0]  new_r;
  logic [3:0]       chg_r;

  // colon countdown
  logic [CW-1:0] el_w;
  logic [CW-1:0] left_w;
  logic [CW-1:0] left_dec;
  logic [PW-1:0] prod;
  logic [1:0]    quarter;
  logic [2:0]    stage_new;
  logic          ts_diff;

  always_comb begin
    el_w      = CW'(in_data.elapsed_ms);
    left_w    = CW'(left_r);
    left_dec  = (left_w > el_w) ? left_w - el_w : '0;
    prod      = PW'(left_dec) * PW'(QUARTER_RECIP);
    quarter   = prod[QUARTER_SHIFT +: 2];
    if (in_data.time_synced) begin
      stage_new = (left_dec > SYNC_LIMIT) ? STAGE_DARK : STAGE_LIT;
    end else begin
      stage_new = {1'b0, ~quarter};
    end
    ts_diff = in_data.timestamp_seconds != last_ts_r;
  end

  // divider
  logic [52:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [16:0] quo_nxt;
  logic [16:0] div_base;
  logic [33:0] back_prod;

  always_comb begin
    day_prod  = 53'(rem_r[32:7]) * 53'(DAY_RECIP);
    hour_prod = 27'(rem_r[16:4]) * 27'(HOUR_RECIP);
    min_prod  = 21'(rem_r[11:2]) * 21'(MIN_RECIP);
    unique case (cmd.div_phase)
      PH_DAY: begin
        quo_nxt  = day_prod[52:36];
        div_base = DAY_SECONDS;
      end
      PH_HOUR: begin
        quo_nxt  = 17'(hour_prod[26:21]);
        div_base = HOUR_SECONDS;
      end
      default: begin
        quo_nxt  = 17'(min_prod[20:14]);
        div_base = '0;
      end
    endcase
    back_prod = 34'(quo_r) * 34'(div_base);
  end

  // digit split
  logic [3:0][3:0] nd;
  logic [3:0]      nchg;

  always_comb begin
    nd[0] = tens_of({1'b0, hour_r});
    nd[1] = ones_of({1'b0, hour_r});
    nd[2] = tens_of(quo_r[5:0]);
    nd[3] = ones_of(quo_r[5:0]);
    for (int i = 0; i < 4; i++) begin
      nchg[i] = nd[i] != shown_r[i];
    end
  end

  // output word
  logic       dev;
  logic [2:0] ga;
  logic [2:0] gb;
  logic [7:0] row_val;
  logic [3:0] pat;
  out_item_t  emit_item;

  always_comb begin
    dev     = cmd.digit_idx[1];
    ga      = glyph_row(glyphs, shown_r[{dev, 1'b1}], cmd.sub_idx);
    gb      = glyph_row(glyphs, shown_r[{dev, 1'b0}], cmd.sub_idx);
    row_val = dev ? {ga, 1'b0, gb, 1'b0} : {1'b0, ga, 1'b0, gb};
    pat     = colon_pattern(stage_r);
    emit_item = '0;
    unique case (cmd.emit_sel)
      EMIT_INTENSITY: begin
        emit_item.write_kind    = KIND_INTENSITY;
        emit_item.device_number = cmd.sub_idx[0];
        emit_item.write_value   = {4'd0, bright_r};
      end
      EMIT_ROW: begin
        emit_item.write_kind    = KIND_ROW;
        emit_item.device_number = dev;
        emit_item.row_number    = ~cmd.sub_idx;
        emit_item.write_value   = row_val;
      end
      EMIT_LED: begin
        emit_item.write_kind  = KIND_LED;
        emit_item.write_value = {7'd0, pat[cmd.sub_idx[1:0]]};
        unique case (cmd.sub_idx[1:0])
          2'd0: begin
            emit_item.device_number = 1'b0;
            emit_item.row_number    = 3'd3;
            emit_item.column_number = 3'd0;
          end
          2'd1: begin
            emit_item.device_number = 1'b0;
            emit_item.row_number    = 3'd4;
            emit_item.column_number = 3'd0;
          end
          2'd2: begin
            emit_item.device_number = 1'b1;
            emit_item.row_number    = 3'd4;
            emit_item.column_number = 3'd7;
          end
          default: begin
            emit_item.device_number = 1'b1;
            emit_item.row_number    = 3'd3;
            emit_item.column_number = 3'd7;
          end
        endcase
      end
      default: emit_item = '0;
    endcase
    emit_item.last_write = cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r   <= '0;
      stage_r     <= STAGE_DARK;
      left_r      <= PERIOD;
      shown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture && !in_data.action) begin
        last_ts_r <= in_data.timestamp_seconds;
        stage_r   <= stage_new;
        left_r    <= (left_dec == '0) ? PERIOD : left_dec[LW-1:0];
      end
      if (cmd.set_digit) begin
        shown_r[cmd.digit_idx] <= new_r[cmd.digit_idx];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_r          <= in_data.timestamp_seconds;
      action_r      <= in_data.action;
      ts_changed_r  <= ts_diff;
      colon_write_r <= ts_diff || (stage_new != stage_r);
      bright_r      <= (in_data.brightness_level > 8'd15) ? 4'd15
                                                           : in_data.brightness_level[3:0];
    end
    if (cmd.load_sum) begin
      rem_r <= {2'b00, ts_r} + {{16{tz_offset[17]}}, tz_offset} + DAY_BIAS;
    end else if (cmd.div_step && cmd.div_rem) begin
      rem_r <= rem_r - back_prod;
    end
    if (cmd.div_step && !cmd.div_rem) begin
      quo_r <= quo_nxt;
    end
    if (cmd.latch_hour) begin
      hour_r <= quo_r[4:0];
    end
    if (cmd.decide) begin
      new_r <= nd;
      chg_r <= nchg;
    end
    if (cmd.emit) begin
      out_data_r <= emit_item;
    end
  end

  assign status.action      = action_r;
  assign status.ts_changed  = ts_changed_r;
  assign status.colon_write = colon_write_r;
  assign status.digit_chg   = chg_r;
  assign status.out_free    = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;

endmodule

// ===== rtl/cfld_ctrl.sv =====
`timescale 1ns / 1ps
// cfld_ctrl: sequencer for divider steps, digit checks and write bursts
// depends on cfld_pkg; drives cfld_datapath through dp_cmd_t

module cfld_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfld_pkg::dp_status_t status,
  output cfld_pkg::dp_cmd_t    cmd
);
  import cfld_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_BRIGHT = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIGCHK = 3'd5;
  localparam logic [2:0] S_ROWS   = 3'd6;
  localparam logic [2:0] S_COLON  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       part_r, part_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [3:0] above;
  logic       more_rows;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    part_nxt  = part_r;
    idx_nxt   = idx_r;
    sub_nxt   = sub_r;
    cmd           = '0;
    cmd.div_phase = phase_r;
    cmd.div_rem   = part_r;
    cmd.digit_idx = idx_r;
    cmd.sub_idx   = sub_r;
    in_ready      = 1'b0;
    above     = status.digit_chg >> idx_r;
    more_rows = |above[3:1];

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        cmd.load_sum = 1'b1;
        phase_nxt    = PH_DAY;
        part_nxt     = 1'b0;
        idx_nxt      = 2'd0;
        sub_nxt      = 3'd0;
        priority if (status.action) begin
          state_nxt = S_BRIGHT;
        end else if (status.ts_changed) begin
          state_nxt = S_DIV;
        end else if (status.colon_write) begin
          state_nxt = S_COLON;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BRIGHT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_INTENSITY;
          cmd.emit_last = sub_r[0];
          if (sub_r[0]) begin
            state_nxt = S_IDLE;
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step   = 1'b1;
        cmd.latch_hour = (phase_r == PH_HOUR) && part_r;
        priority if (phase_r == PH_MIN) begin
          state_nxt = S_DECIDE;
        end else if (part_r) begin
          part_nxt  = 1'b0;
          phase_nxt = (phase_r == PH_DAY) ? PH_HOUR : PH_MIN;
        end else begin
          part_nxt = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        idx_nxt    = 2'd0;
        state_nxt  = S_DIGCHK;
      end
      S_DIGCHK: begin
        priority if (status.digit_chg[idx_r]) begin
          cmd.set_digit = 1'b1;
          sub_nxt       = 3'd0;
          state_nxt     = S_ROWS;
        end else if (idx_r == 2'd3) begin
          sub_nxt   = 3'd0;
          state_nxt = status.colon_write ? S_COLON : S_IDLE;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_ROWS: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_ROW;
          cmd.emit_last = (sub_r == 3'd7) && !more_rows && !status.colon_write;
          if (sub_r == 3'd7) begin
            sub_nxt = 3'd0;
            if (idx_r == 2'd3) begin
              state_nxt = status.colon_write ? S_COLON : S_IDLE;
            end else begin
              idx_nxt   = idx_r + 2'd1;
              state_nxt = S_DIGCHK;
            end
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end
      S_COLON: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_LED;
          cmd.emit_last = sub_r[1:0] == 2'd3;
          if (sub_r[1:0] == 2'd3) begin
            state_nxt = S_IDLE;
          end else begin
            sub_nxt = sub_r + 3'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DAY;
      part_r  <= 1'b0;
      idx_r   <= '0;
      sub_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

// ===== rtl/clock_face_led_matrix_driver_core.sv =====
`timescale 1ns / 1ps
// clock_face_led_matrix_driver_core: top level of the two-device hh:mm display driver
// depends on cfld_pkg, cfld_cfg_regs, cfld_ctrl, cfld_datapath
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+--------------------------
//   in_      | in_valid / in_ready            | in_data   (in_item_t)
//   out_     | out_valid / out_ready          | out_data  (out_item_t)
//   cfg_     | psel, penable, pwrite / pready | paddr, pwdata, prdata
//
// one request at a time; a tick with a new time runs 5 reciprocal-multiply divider
// steps, then digit checks, rows and colon; the output register holds a finished
// write while the next request is taken; a stalled out_ready holds the sequencer;
// reset clears state

module clock_face_led_matrix_driver_core #(
  parameter int unsigned COLON_PERIOD_MS = 2000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cfld_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cfld_pkg::out_item_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cfld_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cfld_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cfld_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import cfld_pkg::*;

  logic [17:0]  tz_offset;
  glyph_bank_t  glyphs;
  dp_cmd_t      cmd;
  dp_status_t   status;

  cfld_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .tz_offset   (tz_offset),
    .glyphs      (glyphs)
  );

  cfld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfld_datapath #(
    .COLON_PERIOD_MS (COLON_PERIOD_MS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .tz_offset (tz_offset),
    .glyphs    (glyphs),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/cfld_checker.sv =====
`timescale 1ns / 1ps
// cfld_checker: port-level assertions for clock_face_led_matrix_driver_core
// depends on cfld_pkg; bound to the top level below

module cfld_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input cfld_pkg::out_item_t          out_data
);
  import cfld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_intensity_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_kind == KIND_INTENSITY |->
      out_data.row_number == 3'd0 && out_data.column_number == 3'd0 &&
      out_data.write_value <= 8'd15)
    else $error("intensity write with bad fields");

  a_led_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_kind == KIND_LED |->
      out_data.write_value[7:1] == 7'd0 &&
      (out_data.column_number == 3'd0 || out_data.column_number == 3'd7))
    else $error("led write with bad fields");

endmodule

bind clock_face_led_matrix_driver_core cfld_checker u_cfld_checker (.*);
